FILE: hdl/qoi_pkg.sv
// Shared types, opcode constants and helper functions for the QOI chunk decoder.
// No dependencies; used by qoi_ctrl, qoi_datapath and qoi_chunk_decoder.
`default_nettype none

package qoi_pkg;

    localparam int CHUNK_MAX = 5;
    localparam int INDEX_DEPTH = 64;

    localparam logic [7:0] TAG_RGBA = 8'hFF;
    localparam logic [7:0] TAG_RGB  = 8'hFE;

    localparam logic [1:0] OP_INDEX = 2'b00;
    localparam logic [1:0] OP_DIFF  = 2'b01;
    localparam logic [1:0] OP_LUMA  = 2'b10;
    localparam logic [1:0] OP_RUN   = 2'b11;

    localparam logic [2:0] LEN_RGBA  = 3'd5;
    localparam logic [2:0] LEN_RGB   = 3'd4;
    localparam logic [2:0] LEN_LUMA  = 3'd2;
    localparam logic [2:0] LEN_SHORT = 3'd1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] DIFF_BIAS    = 8'd2;
    localparam logic [7:0] LUMA_G_BIAS  = 8'd32;
    localparam logic [7:0] LUMA_RB_BIAS = 8'd8;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } pixel_t;

    // controller -> datapath
    typedef struct packed {
        logic       capture;   // take data_byte into chunk slot
        logic [2:0] slot;
        logic       decode;    // build pixel from the completed chunk
        logic       emit;      // load output register with previous pixel
        logic       last;      // final pixel of this chunk
    } qoi_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] byte_len;  // chunk length if data_byte opens a chunk
        logic [5:0] run_len;   // extra repeats of the decoded pixel
        logic       out_free;  // output register can take a beat
    } qoi_status_t;

    function automatic logic [2:0] chunk_len(input logic [7:0] first);
        logic [2:0] len;
        if (first == TAG_RGBA)
            len = LEN_RGBA;
        else if (first == TAG_RGB)
            len = LEN_RGB;
        else if (first[7:6] == OP_LUMA)
            len = LEN_LUMA;
        else
            len = LEN_SHORT;
        return len;
    endfunction

    // (3r + 5g + 7b + 11a) mod 64: only the low six bits of each channel matter
    function automatic logic [5:0] hash_slot(input pixel_t p);
        logic [5:0] s;
        s = 6'(p.r[5:0] * 6'd3) + 6'(p.g[5:0] * 6'd5)
          + 6'(p.b[5:0] * 6'd7) + 6'(p.a[5:0] * 6'd11);
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/qoi_ctrl.sv
// Sequencer for the QOI chunk decoder: chunk assembly, decode and pixel emission.
// Depends on qoi_pkg; drives qoi_datapath through qoi_cmd_t.
`default_nettype none

module qoi_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire qoi_pkg::qoi_status_t st,
    output qoi_pkg::qoi_cmd_t         cmd
);

    typedef enum logic [1:0] {
        S_COLLECT,
        S_DECODE,
        S_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] fill_reg, fill_next;
    logic [2:0] len_reg, len_next;
    logic [5:0] run_reg, run_next;

    logic       accept;
    logic [2:0] fill_inc;
    logic [2:0] cur_len;

    assign accept   = in_valid && !in_stall;
    assign fill_inc = fill_reg + 3'd1;
    assign cur_len  = (fill_reg == 3'd0) ? st.byte_len : len_reg;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        run_next   = run_reg;
        in_stall   = 1'b1;
        cmd        = '0;
        cmd.slot   = fill_reg;
        cmd.last   = (run_reg == 6'd0);

        unique case (state_reg)
            S_COLLECT:
            begin
                in_stall    = 1'b0;
                cmd.capture = accept;
                if (accept)
                begin
                    len_next = cur_len;
                    if (fill_inc >= cur_len)
                    begin
                        fill_next  = 3'd0;
                        state_next = S_DECODE;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                run_next   = st.run_len;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit = st.out_free;
                if (st.out_free)
                begin
                    if (run_reg == 6'd0)
                        state_next = S_COLLECT;
                    else
                        run_next = run_reg - 6'd1;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
            fill_reg  <= 3'd0;
            len_reg   <= 3'd0;
            run_reg   <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            run_reg   <= run_next;
        end
    end

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < 3'(qoi_pkg::CHUNK_MAX))
        else $error("chunk fill beyond chunk store");

    a_decode_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decode |=> !cmd.decode && !cmd.capture)
        else $error("decode not followed by emission");

    a_no_capture_mid_chunk_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !cmd.last) |=> !cmd.capture)
        else $error("byte taken before run finished");

endmodule

`default_nettype wire

FILE: hdl/qoi_datapath.sv
// Datapath of the QOI chunk decoder: chunk store, pixel arithmetic, color index
// memory with valid bits, pixel countdown and output register. Depends on qoi_pkg.
`default_nettype none

module qoi_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 cfg_wr_en,
    input  wire logic [31:0]          cfg_wr_data,
    input  wire qoi_pkg::qoi_cmd_t    cmd,
    output qoi_pkg::qoi_status_t      st,
    input  wire logic                 out_stall,
    output logic                      out_valid,
    output logic [7:0]                red,
    output logic [7:0]                green,
    output logic [7:0]                blue,
    output logic [7:0]                alpha,
    output logic                      last_of_burst,
    output logic                      image_done
);

    logic [7:0]       chunk_reg [qoi_pkg::CHUNK_MAX];
    qoi_pkg::pixel_t  prev_reg, px_next;
    logic             store;

    // color index: memory plus per-entry valid bits (unwritten entries read zero)
    logic [31:0]                        cidx_mem [qoi_pkg::INDEX_DEPTH];
    logic [qoi_pkg::INDEX_DEPTH-1:0]    valid_reg;
    logic [31:0]                        rd_data_reg;
    logic                               rd_valid_reg;
    logic [5:0]                         wr_addr;
    logic                               mem_wr;

    logic [31:0] remaining_reg, remaining_next;

    logic            out_valid_reg;
    qoi_pkg::pixel_t out_px_reg;
    logic            out_last_reg;
    logic            out_done_reg;

    logic [7:0] hdr;
    logic [7:0] dg;

    assign hdr = chunk_reg[0];
    assign dg  = {2'b00, hdr[5:0]} - qoi_pkg::LUMA_G_BIAS;

    always_comb
    begin
        px_next = prev_reg;
        store   = 1'b1;
        if (hdr == qoi_pkg::TAG_RGBA)
        begin
            px_next = {chunk_reg[1], chunk_reg[2], chunk_reg[3], chunk_reg[4]};
        end
        else if (hdr == qoi_pkg::TAG_RGB)
        begin
            px_next = {chunk_reg[1], chunk_reg[2], chunk_reg[3], prev_reg.a};
        end
        else
        begin
            unique case (hdr[7:6])
                qoi_pkg::OP_INDEX:
                begin
                    px_next = rd_valid_reg ? qoi_pkg::pixel_t'(rd_data_reg) : '0;
                    store   = 1'b0;
                end
                qoi_pkg::OP_DIFF:
                begin
                    px_next.r = prev_reg.r + {6'b0, hdr[5:4]} - qoi_pkg::DIFF_BIAS;
                    px_next.g = prev_reg.g + {6'b0, hdr[3:2]} - qoi_pkg::DIFF_BIAS;
                    px_next.b = prev_reg.b + {6'b0, hdr[1:0]} - qoi_pkg::DIFF_BIAS;
                end
                qoi_pkg::OP_LUMA:
                begin
                    px_next.g = prev_reg.g + dg;
                    px_next.r = prev_reg.r + dg + {4'b0, chunk_reg[1][7:4]}
                              - qoi_pkg::LUMA_RB_BIAS;
                    px_next.b = prev_reg.b + dg + {4'b0, chunk_reg[1][3:0]}
                              - qoi_pkg::LUMA_RB_BIAS;
                end
                qoi_pkg::OP_RUN:
                begin
                    store = 1'b0;
                end
                default:
                begin
                    store = 1'b0;
                end
            endcase
        end
    end

    assign mem_wr  = cmd.decode && store;
    assign wr_addr = qoi_pkg::hash_slot(px_next);

    always_comb
    begin
        st.byte_len = qoi_pkg::chunk_len(data_byte);
        st.run_len  = (hdr[7:6] == qoi_pkg::OP_RUN && hdr != qoi_pkg::TAG_RGBA
                       && hdr != qoi_pkg::TAG_RGB) ? hdr[5:0] : 6'd0;
        st.out_free = !out_valid_reg || !out_stall;
    end

    assign remaining_next = (remaining_reg == 32'd0) ? 32'd0 : remaining_reg - 32'd1;

    // chunk store, index table, table read data and output pixel fields: no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            chunk_reg[cmd.slot] <= data_byte;
            // speculative read: only used when this byte is an INDEX header
            rd_data_reg <= cidx_mem[data_byte[5:0]];
        end
        if (mem_wr)
            cidx_mem[wr_addr] <= px_next;
        if (cmd.emit)
        begin
            out_px_reg   <= prev_reg;
            out_last_reg <= cmd.last;
            out_done_reg <= (remaining_next == 32'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            prev_reg      <= {8'd0, 8'd0, 8'd0, qoi_pkg::ALPHA_OPAQUE};
            remaining_reg <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
                rd_valid_reg <= valid_reg[data_byte[5:0]];
            if (mem_wr)
                valid_reg[wr_addr] <= 1'b1;
            if (cmd.decode)
                prev_reg <= px_next;
            if (cfg_wr_en)
                remaining_reg <= cfg_wr_data;
            else if (cmd.emit)
                remaining_reg <= remaining_next;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red           = out_px_reg.r;
    assign green         = out_px_reg.g;
    assign blue          = out_px_reg.b;
    assign alpha         = out_px_reg.a;
    assign last_of_burst = out_last_reg;
    assign image_done    = out_done_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.emit)
        else $error("held output beat overwritten");

    a_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_wr_en |=> remaining_reg <= $past(remaining_reg))
        else $error("pixel countdown increased without config write");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr && cmd.capture))
        else $error("index table written during byte capture");

endmodule

`default_nettype wire

FILE: hdl/qoi_chunk_decoder.sv
// QOI chunk decoder top level: joins the qoi_ctrl sequencer and qoi_datapath.
// Depends on qoi_pkg, qoi_ctrl and qoi_datapath.
//
// Input channel: one compressed byte per beat on data_byte (in_valid / in_stall).
// Output channel: one decoded pixel per beat on red/green/blue/alpha with
// last_of_burst on the final pixel of a chunk and image_done once the pixel
// countdown is at zero (out_valid / out_stall).
// Config: cfg_wr_en with cfg_wr_data loads the image pixel count; write only
// while the decoder is idle.
// Timing: bytes that do not complete a chunk are taken one per cycle. The byte
// that completes a chunk is followed by a decode step, then emission of its
// pixels (a single pixel, or up to 62 for a run) while in_stall is high. The
// completing byte enters the chunk store, the decode step writes the previous
// pixel register and each emit loads the output register from that register.
// The output register lets the next byte be taken while the last pixel waits.
// Stalling the output holds the current pixel and pauses emission.
// Reset clears the index table valid bits, sets the previous pixel to opaque
// black and the pixel countdown to zero; no clearing pass is needed.
`default_nettype none

module qoi_chunk_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic [7:0]       alpha,
    output logic             last_of_burst,
    output logic             image_done
);

    qoi_pkg::qoi_cmd_t    cmd;
    qoi_pkg::qoi_status_t st;

    qoi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    qoi_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .cmd           (cmd),
        .st            (st),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha         (alpha),
        .last_of_burst (last_of_burst),
        .image_done    (image_done)
    );

endmodule

`default_nettype wire

FILE: verif/qoi_chunk_decoder_test.sv
// Self-checking testbench for qoi_chunk_decoder: feeds QOI chunk bytes and
// compares every decoded pixel against an in-bench predictor of the decoder.
// Depends on qoi_pkg (pixel type, tags and opcode constants) and the RTL.

module qoi_chunk_decoder_test;

    typedef struct packed {
        qoi_pkg::pixel_t px;
        logic            last_of_burst;
        logic            image_done;
    } pixel_result_t;

    typedef enum int {
        GEN_INDEX,
        GEN_DIFF,
        GEN_LUMA,
        GEN_RGB,
        GEN_RGBA,
        GEN_RUN,
        GEN_NOISE
    } chunk_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last_of_burst;
    logic        image_done;

    // stimulus bookkeeping
    logic [7:0]      pending_bytes[$];
    pixel_result_t   expected_pixels[$];
    int              bytes_pushed = 0;
    int              bytes_taken = 0;
    int              pixels_checked = 0;
    int              runs_decoded = 0;
    int              table_writes = 0;
    int              mismatches = 0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;

    // predictor state
    qoi_pkg::pixel_t color_table[qoi_pkg::INDEX_DEPTH];
    qoi_pkg::pixel_t prev_px;
    logic [7:0]      chunk_buf[qoi_pkg::CHUNK_MAX];
    logic [2:0]      chunk_fill;
    logic [2:0]      chunk_len;
    logic [31:0]     pixels_left;

    qoi_chunk_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha         (alpha),
        .last_of_burst (last_of_burst),
        .image_done    (image_done)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic predict_pixels(input logic [7:0] b);
        qoi_pkg::pixel_t px;
        logic [7:0]      head;
        logic [7:0]      lo;
        logic [7:0]      dg;
        int              reps;
        int              sum;
        bit              keep;
        pixel_result_t   res;
        chunk_buf[chunk_fill] = b;
        chunk_fill++;
        if (chunk_fill == 3'd1)
        begin
            if (b == qoi_pkg::TAG_RGBA)
                chunk_len = qoi_pkg::LEN_RGBA;
            else if (b == qoi_pkg::TAG_RGB)
                chunk_len = qoi_pkg::LEN_RGB;
            else if (b[7:6] == qoi_pkg::OP_LUMA)
                chunk_len = qoi_pkg::LEN_LUMA;
            else
                chunk_len = qoi_pkg::LEN_SHORT;
        end
        if (chunk_fill < chunk_len)
            return;

        px = prev_px;
        head = chunk_buf[0];
        keep = 1'b1;
        reps = 1;
        if (head == qoi_pkg::TAG_RGBA)
        begin
            px.r = chunk_buf[1];
            px.g = chunk_buf[2];
            px.b = chunk_buf[3];
            px.a = chunk_buf[4];
        end
        else if (head == qoi_pkg::TAG_RGB)
        begin
            px.r = chunk_buf[1];
            px.g = chunk_buf[2];
            px.b = chunk_buf[3];
        end
        else
        begin
            case (head[7:6])
                qoi_pkg::OP_INDEX:
                begin
                    px = color_table[head[5:0]];
                    keep = 1'b0;
                end
                qoi_pkg::OP_DIFF:
                begin
                    px.r = px.r + {6'b0, head[5:4]} - qoi_pkg::DIFF_BIAS;
                    px.g = px.g + {6'b0, head[3:2]} - qoi_pkg::DIFF_BIAS;
                    px.b = px.b + {6'b0, head[1:0]} - qoi_pkg::DIFF_BIAS;
                end
                qoi_pkg::OP_LUMA:
                begin
                    lo = chunk_buf[1];
                    dg = {2'b0, head[5:0]} - qoi_pkg::LUMA_G_BIAS;
                    px.g = px.g + dg;
                    px.r = px.r + dg + {4'b0, lo[7:4]} - qoi_pkg::LUMA_RB_BIAS;
                    px.b = px.b + dg + {4'b0, lo[3:0]} - qoi_pkg::LUMA_RB_BIAS;
                end
                default:
                begin
                    reps = int'(head[5:0]) + 1;
                    keep = 1'b0;
                    runs_decoded++;
                end
            endcase
        end

        if (keep)
        begin
            sum = 3 * int'(px.r) + 5 * int'(px.g) + 7 * int'(px.b) + 11 * int'(px.a);
            // slot is the sum mod 64, i.e. its low six bits
            color_table[6'(sum)] = px;
            table_writes++;
        end
        prev_px = px;
        chunk_fill = 3'd0;
        chunk_len = 3'd0;

        for (int k = 0; k < reps; k++)
        begin
            if (pixels_left != 0)
                pixels_left--;
            res.px = px;
            res.last_of_burst = (k == reps - 1);
            res.image_done = (pixels_left == 0);
            expected_pixels.push_back(res);
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_pushed++;
    endtask

    task automatic push_random_chunk();
        int          pick;
        chunk_kind_t kind;
        logic [7:0]  head;
        logic [2:0]  len;
        pick = $urandom_range(99);
        if (pick < 14)
            kind = GEN_INDEX;
        else if (pick < 30)
            kind = GEN_DIFF;
        else if (pick < 46)
            kind = GEN_LUMA;
        else if (pick < 58)
            kind = GEN_RGB;
        else if (pick < 70)
            kind = GEN_RGBA;
        else if (pick < 85)
            kind = GEN_RUN;
        else
            kind = GEN_NOISE;

        case (kind)
            GEN_INDEX:
                push_byte({qoi_pkg::OP_INDEX, 6'($urandom_range(63))});
            GEN_DIFF:
                push_byte({qoi_pkg::OP_DIFF, 6'($urandom_range(63))});
            GEN_LUMA:
            begin
                push_byte({qoi_pkg::OP_LUMA, 6'($urandom_range(63))});
                push_byte(8'($urandom_range(255)));
            end
            GEN_RGB:
            begin
                push_byte(qoi_pkg::TAG_RGB);
                repeat (3) push_byte(8'($urandom_range(255)));
            end
            GEN_RGBA:
            begin
                push_byte(qoi_pkg::TAG_RGBA);
                repeat (4) push_byte(8'($urandom_range(255)));
            end
            GEN_RUN:
            begin
                // mostly short runs, now and then a long one
                if ($urandom_range(9) < 8)
                    push_byte({qoi_pkg::OP_RUN, 6'($urandom_range(7))});
                else
                    push_byte({qoi_pkg::OP_RUN, 6'($urandom_range(61))});
            end
            default:
            begin
                // arbitrary byte, completed with arbitrary payload
                head = 8'($urandom_range(255));
                len = qoi_pkg::chunk_len(head);
                push_byte(head);
                repeat (len - 3'd1) push_byte(8'($urandom_range(255)));
            end
        endcase
    endtask

    task automatic wait_idle();
        while (bytes_taken != bytes_pushed || expected_pixels.size() != 0)
            @(posedge clk);
        // let the decode pipe drain before touching the register
        repeat (8) @(posedge clk);
    endtask

    task automatic write_pixel_count(input logic [31:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pixels_left = value;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    // driver: one beat at a time from the pending queue
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_pixels(data_byte);
                bytes_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    data_byte <= pending_bytes.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each pixel beat against the oldest expectation
    always @(posedge clk)
    begin : monitor
        pixel_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel beat with nothing expected: %0h %0h %0h %0h",
                           red, green, blue, alpha);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("red", want.px.r, red);
                    check_field("green", want.px.g, green);
                    check_field("blue", want.px.b, blue);
                    check_field("alpha", want.px.a, alpha);
                    check_field("last_of_burst", 8'(want.last_of_burst), 8'(last_of_burst));
                    check_field("image_done", 8'(want.image_done), 8'(image_done));
                    pixels_checked++;
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        color_table = '{default: '0};
        prev_px = '{r: 8'h00, g: 8'h00, b: 8'h00, a: qoi_pkg::ALPHA_OPAQUE};
        chunk_fill = 3'd0;
        chunk_len = 3'd0;
        pixels_left = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // small image: countdown reaches zero and then saturates
        send_idle_pct = 28;
        recv_idle_pct = 60;
        write_pixel_count(32'd12);
        push_byte({qoi_pkg::OP_INDEX, 6'd0});       // cleared table entry
        push_byte({qoi_pkg::OP_INDEX, 6'd63});
        push_byte({qoi_pkg::OP_DIFF, 6'b000000});   // -2 on red, green and blue, wraps
        push_byte({qoi_pkg::OP_DIFF, 6'b111111});
        push_byte({qoi_pkg::OP_DIFF, 6'b101010});   // zero delta
        push_byte({qoi_pkg::OP_LUMA, 6'd0});        // most negative luma
        push_byte(8'h00);
        push_byte({qoi_pkg::OP_LUMA, 6'd63});       // most positive luma
        push_byte(8'hFF);
        push_byte(qoi_pkg::TAG_RGB);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(qoi_pkg::TAG_RGBA);
        push_byte(8'h12);
        push_byte(8'h34);
        push_byte(8'h56);
        push_byte(8'h00);
        push_byte(qoi_pkg::TAG_RGBA);
        repeat (4) push_byte(8'hFF);
        push_byte({qoi_pkg::OP_RUN, 6'd0});
        push_byte({qoi_pkg::OP_RUN, 6'd61});        // longest run
        push_byte({qoi_pkg::OP_INDEX, 6'($urandom_range(63))});
        while (bytes_pushed < 90)
            push_random_chunk();
        wait_idle();

        send_idle_pct = 60;
        recv_idle_pct = 28;
        write_pixel_count(32'hFFFF_FFFF);
        while (bytes_pushed < 170)
            push_random_chunk();
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_pixel_count(32'd0);
        while (bytes_pushed < 250)
            push_random_chunk();

        while (bytes_taken != bytes_pushed || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            $error("%0d expected pixels never arrived", expected_pixels.size());
            mismatches++;
        end

        $display("Decoded %0d chunk bytes into %0d checked pixels (%0d runs, %0d writes)",
                 bytes_taken, pixels_checked, runs_decoded, table_writes);
        $display("Pixel counts 12, max and zero, under sender, receiver and no back-pressure");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Timed out waiting for the decoder");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
